>>> src/modbus_rtu_request_receiver_core_macros.svh
// Assertion macros shared by the Modbus RTU request receiver checkers.
// Included by the checker file; needs nothing else.
`ifndef MODBUS_RTU_REQUEST_RECEIVER_CORE_MACROS_SVH
`define MODBUS_RTU_REQUEST_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MBRX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbrx assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MBRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbrx assertion failed");

// Next-cycle implication that also holds through reset
`define MBRX_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mbrx assertion failed");

`endif

>>> src/mbrx_pkg.sv
// Types, codes and constants of the Modbus RTU request receiver.
// No dependencies; imported by every module of the block.
package mbrx_pkg;

    localparam int unsigned BUFFER_BYTES = 255;
    localparam int unsigned HDR_BYTES    = 7;
    localparam int unsigned MIN_FRAME    = 4;

    // Field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned COILS_W = 11;
    localparam int unsigned REGS_W  = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned OUT_W   = 56;

    // Function codes
    localparam logic [7:0] FC_READ_COILS  = 8'h01;
    localparam logic [7:0] FC_READ_REGS   = 8'h03;
    localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
    localparam logic [7:0] FC_WRITE_REG   = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
    localparam logic [7:0] FC_SLAVE_ID    = 8'h11;

    localparam logic [7:0] COIL_ON  = 8'hFF;
    localparam logic [7:0] COIL_OFF = 8'h00;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_ARM  = 2'd2,
        CMD_OFF  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_READ     = 3'd1,
        MODE_READ_ERR = 3'd2,
        MODE_READY    = 3'd3,
        MODE_EXC      = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_OK         = 3'd1,
        ST_WRONG_ADDR = 3'd2,
        ST_CRC_BAD    = 3'd3,
        ST_ILL_FUNC   = 3'd4,
        ST_ILL_DATA   = 3'd5,
        ST_ABORTED    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CFG_TICK_STEP      = 3'd0,
        CFG_RESET_GAP      = 3'd1,
        CFG_READ_GAP       = 3'd2,
        CFG_MAX_COILS      = 3'd3,
        CFG_MAX_REGS       = 3'd4,
        CFG_DEVICE_ADDRESS = 3'd5,
        CFG_ADDRESS_VALID  = 3'd6
    } t_cfg_idx;

    typedef logic [HDR_BYTES-1:0][BYTE_W-1:0] t_hdr;

    typedef struct packed {
        logic [WORD_W-1:0]  tick_step;
        logic [WORD_W-1:0]  reset_gap;
        logic [WORD_W-1:0]  read_gap;
        logic [COILS_W-1:0] max_coils;
        logic [REGS_W-1:0]  max_registers;
        logic [BYTE_W-1:0]  device_address;
        logic               address_valid;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] quantity;
    } t_chk;

    typedef struct packed {
        logic [WORD_W-1:0] quantity;
        logic [WORD_W-1:0] start_address;
        logic [BYTE_W-1:0] function_code;
        logic [BYTE_W-1:0] byte_count;
        t_mode             mode;
        t_status           status;
    } t_result;

endpackage

>>> src/mbrx_crc.sv
// One byte step of CRC-16/MODBUS (reflected polynomial 0xA001).
// Depends on mbrx_pkg.
module mbrx_crc (
    input  logic [mbrx_pkg::WORD_W-1:0] i_crc,
    input  logic [mbrx_pkg::BYTE_W-1:0] i_byte,
    output logic [mbrx_pkg::WORD_W-1:0] o_crc
);
    import mbrx_pkg::*;

    // Fold the byte in, then shift out eight bits
    always_comb begin
        logic [WORD_W-1:0] c;
        c = i_crc ^ {{(WORD_W-BYTE_W){1'b0}}, i_byte};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

>>> src/mbrx_check.sv
// Function code and quantity check of a received request header.
// Depends on mbrx_pkg.
module mbrx_check (
    input  mbrx_pkg::t_hdr               i_hdr,
    input  logic [mbrx_pkg::COILS_W-1:0] i_max_coils,
    input  logic [mbrx_pkg::REGS_W-1:0]  i_max_registers,
    output mbrx_pkg::t_chk               o_chk
);
    import mbrx_pkg::*;

    logic [WORD_W-1:0] w_adr;
    logic [WORD_W-1:0] w_num;
    logic [WORD_W:0]   w_num_p7;
    logic [WORD_W:0]   w_num_x2;
    logic              w_coils_ok;
    logic              w_regs_ok;
    logic              w_coil_val_ok;

    assign w_adr    = {i_hdr[2], i_hdr[3]};
    assign w_num    = {i_hdr[4], i_hdr[5]};
    assign w_num_p7 = {1'b0, w_num} + (WORD_W+1)'(7);
    assign w_num_x2 = {w_num, 1'b0};

    assign w_coils_ok = (w_num != '0) && (w_num <= {{(WORD_W-COILS_W){1'b0}}, i_max_coils});
    assign w_regs_ok  = (w_num != '0) && (w_num <= {{(WORD_W-REGS_W){1'b0}}, i_max_registers});

    // Single coil value must be 0x0000 or 0xFF00
    assign w_coil_val_ok = (i_hdr[5] == COIL_OFF) &&
                           ((i_hdr[4] == COIL_OFF) || (i_hdr[4] == COIL_ON));

    // Classify the request; start is reported as address plus one (zero for slave ID)
    always_comb begin
        o_chk.status   = ST_OK;
        o_chk.start    = w_adr + WORD_W'(1);
        o_chk.quantity = w_num;
        unique case (i_hdr[1])
            FC_READ_COILS: begin
                if (!w_coils_ok) o_chk.status = ST_ILL_DATA;
            end
            FC_WRITE_COILS: begin
                if (!w_coils_ok || (w_num_p7[WORD_W:3] != {6'd0, i_hdr[6]})) begin
                    o_chk.status = ST_ILL_DATA;
                end
            end
            FC_READ_REGS: begin
                if (!w_regs_ok) o_chk.status = ST_ILL_DATA;
            end
            FC_WRITE_REGS: begin
                if (!w_regs_ok || (w_num_x2 != {9'd0, i_hdr[6]})) begin
                    o_chk.status = ST_ILL_DATA;
                end
            end
            FC_WRITE_COIL: begin
                o_chk.quantity = WORD_W'(1);
                if (!w_coil_val_ok) begin
                    o_chk.status = ST_ILL_DATA;
                end
            end
            FC_WRITE_REG: begin
                o_chk.quantity = WORD_W'(1);
            end
            FC_SLAVE_ID: begin
                o_chk.start    = '0;
                o_chk.quantity = '0;
            end
            default: begin
                o_chk.status = ST_ILL_FUNC;
            end
        endcase
    end

endmodule

>>> src/mbrx_rx.sv
// Receiver state: framing by silence, header capture, running CRC and the
// end-of-frame decision. Depends on mbrx_pkg, mbrx_crc and mbrx_check.
module mbrx_rx (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbrx_pkg::t_cfg                i_cfg,
    input  logic                          i_take,
    input  mbrx_pkg::t_cmd                i_cmd,
    input  logic [mbrx_pkg::BYTE_W-1:0]   i_rx_byte,
    output mbrx_pkg::t_result             o_result
);
    import mbrx_pkg::*;

    t_mode             r_mode,   n_mode;
    logic [7:0]        r_count,  n_count;
    logic [WORD_W-1:0] r_silence, n_silence;
    t_hdr              r_hdr,    n_hdr;
    logic [WORD_W-1:0] r_crc,    n_crc;
    logic [WORD_W-1:0] r_last2,  n_last2;
    logic [WORD_W-1:0] r_start,  n_start;
    logic [WORD_W-1:0] r_qty,    n_qty;
    t_status           w_status;

    logic [WORD_W-1:0] w_crc_fed;
    t_chk              w_chk;
    logic [WORD_W:0]   w_sum;
    logic [WORD_W-1:0] w_sat;
    logic              w_addr_ok;
    logic              w_crc_ok;

    mbrx_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (r_last2[15:8]),
        .o_crc  (w_crc_fed)
    );

    mbrx_check u_check (
        .i_hdr           (r_hdr),
        .i_max_coils     (i_cfg.max_coils),
        .i_max_registers (i_cfg.max_registers),
        .o_chk           (w_chk)
    );

    // Saturating silence accumulation
    assign w_sum = {1'b0, r_silence} + {1'b0, i_cfg.tick_step};
    assign w_sat = w_sum[WORD_W] ? '1 : w_sum[WORD_W-1:0];

    assign w_addr_ok = i_cfg.address_valid && (i_cfg.device_address == r_hdr[0]);
    assign w_crc_ok  = (r_last2[15:8] == r_crc[7:0]) && (r_last2[7:0] == r_crc[15:8]);

    // Next state for one transaction
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_silence = r_silence;
        n_hdr     = r_hdr;
        n_crc     = r_crc;
        n_last2   = r_last2;
        n_start   = r_start;
        n_qty     = r_qty;
        w_status  = ST_NONE;
        unique case (i_cmd)
            CMD_BYTE: begin
                if (r_mode == MODE_READ) begin
                    if ((r_count != '0) && (r_silence >= i_cfg.reset_gap)) begin
                        n_mode   = MODE_READ_ERR;
                        w_status = ST_ABORTED;
                    end else if (r_count < 8'(BUFFER_BYTES)) begin
                        if (r_count < 8'(HDR_BYTES)) n_hdr[r_count[2:0]] = i_rx_byte;
                        if (r_count >= 8'd2) n_crc = w_crc_fed;
                        n_last2 = {r_last2[7:0], i_rx_byte};
                        n_count = r_count + 8'd1;
                    end
                end
                n_silence = '0;
            end
            CMD_TICK: begin
                if (((r_mode == MODE_READ) || (r_mode == MODE_READ_ERR)) &&
                    (r_silence < i_cfg.read_gap)) begin
                    n_silence = w_sat;
                    if (w_sat >= i_cfg.read_gap) begin
                        // Frame complete: check it or drop it
                        if ((r_mode == MODE_READ) && (r_count >= 8'(MIN_FRAME)) &&
                            w_addr_ok && w_crc_ok) begin
                            w_status = w_chk.status;
                            if (w_chk.status == ST_OK) begin
                                n_mode  = MODE_READY;
                                n_start = w_chk.start;
                                n_qty   = w_chk.quantity;
                            end else begin
                                n_mode = MODE_EXC;
                            end
                        end else begin
                            if ((r_mode == MODE_READ) && (r_count >= 8'(MIN_FRAME))) begin
                                w_status = w_addr_ok ? ST_CRC_BAD : ST_WRONG_ADDR;
                            end
                            n_mode  = MODE_READ;
                            n_count = '0;
                            n_crc   = CRC_INIT;
                            n_last2 = '0;
                            n_start = '0;
                            n_qty   = '0;
                        end
                    end
                end
            end
            CMD_ARM: begin
                n_mode    = MODE_READ;
                n_count   = '0;
                n_crc     = CRC_INIT;
                n_last2   = '0;
                n_start   = '0;
                n_qty     = '0;
                n_silence = '0;
            end
            CMD_OFF: begin
                n_mode = MODE_OFF;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Result fields show the state after the transaction
    always_comb begin
        o_result.status        = w_status;
        o_result.mode          = n_mode;
        o_result.byte_count    = n_count;
        o_result.function_code = n_hdr[1];
        o_result.start_address = n_start;
        o_result.quantity      = n_qty;
    end

    // Hold state; advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_count   <= '0;
            r_silence <= '0;
            r_hdr     <= '0;
            r_crc     <= CRC_INIT;
            r_last2   <= '0;
            r_start   <= '0;
            r_qty     <= '0;
        end else if (i_take) begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_silence <= n_silence;
            r_hdr     <= n_hdr;
            r_crc     <= n_crc;
            r_last2   <= n_last2;
            r_start   <= n_start;
            r_qty     <= n_qty;
        end
    end

endmodule

>>> src/modbus_rtu_request_receiver_core.sv
// Top level of the Modbus RTU request receiver: configuration registers,
// stream handshake and result register. Depends on mbrx_pkg and mbrx_rx.
//
// Every input transaction (a received byte, a time tick, arm or switch off)
// yields exactly one result transaction. The block takes one transaction per
// clock cycle unless the result stream stalls: the whole step (CRC byte
// update, silence accumulation, header check) is combinational from the
// state registers to the result register; the result appears on the master
// side in the cycle after acceptance. The slave side stays ready while the
// result register is empty or being taken in the same cycle, so the
// sustained rate is one item per cycle while downstream keeps tready high.
module modbus_rtu_request_receiver_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [mbrx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbrx_pkg::WORD_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
    input  logic [1:0]                       s_axis_tuser,  // [1:0] cmd
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [5:3] mode, [13:6] byte_count, [21:14] function_code,
    // [37:22] start_address, [53:38] quantity, [55:54] zero
    output logic [mbrx_pkg::OUT_W-1:0]       m_axis_tdata
);
    import mbrx_pkg::*;

    t_cfg    r_cfg;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_step      <= '0;
            r_cfg.reset_gap      <= 16'd1500;
            r_cfg.read_gap       <= 16'd3500;
            r_cfg.max_coils      <= 11'd2000;
            r_cfg.max_registers  <= 7'd125;
            r_cfg.device_address <= '0;
            r_cfg.address_valid  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TICK_STEP:      r_cfg.tick_step      <= i_cfg_data;
                CFG_RESET_GAP:      r_cfg.reset_gap      <= i_cfg_data;
                CFG_READ_GAP:       r_cfg.read_gap       <= i_cfg_data;
                CFG_MAX_COILS:      r_cfg.max_coils      <= i_cfg_data[COILS_W-1:0];
                CFG_MAX_REGS:       r_cfg.max_registers  <= i_cfg_data[REGS_W-1:0];
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[BYTE_W-1:0];
                CFG_ADDRESS_VALID:  r_cfg.address_valid  <= i_cfg_data[0];
                default:            r_cfg.address_valid  <= r_cfg.address_valid;
            endcase
        end
    end

    mbrx_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_take    (w_take),
        .i_cmd     (t_cmd'(s_axis_tuser)),
        .i_rx_byte (s_axis_tdata),
        .o_result  (w_result)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-$bits(t_result)){1'b0}}, r_result};

endmodule

>>> src/mbrx_checker.sv
// Port-level checker for the Modbus RTU request receiver and its binding.
// Depends on mbrx_pkg, the assertion macro header and the top level's ports.
`include "modbus_rtu_request_receiver_core_macros.svh"

module mbrx_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [mbrx_pkg::OUT_W-1:0]   m_axis_tdata
);
    import mbrx_pkg::*;

    logic w_in_take;
    logic w_codes_ok;

    assign w_in_take  = s_axis_tvalid && s_axis_tready;
    assign w_codes_ok = (m_axis_tdata[2:0] <= ST_ABORTED) && (m_axis_tdata[5:3] <= MODE_EXC);

    // Reset empties the result register
    `MBRX_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // Every accepted transaction shows a result in the next cycle
    `MBRX_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, w_in_take, m_axis_tvalid)

    // An empty result register never stalls the input
    `MBRX_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // A stalled result stays offered
    `MBRX_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Status and mode stay within their codes
    `MBRX_ASSERT_NOW(a_codes, i_clk, i_rst_n, m_axis_tvalid, w_codes_ok)

endmodule

bind modbus_rtu_request_receiver_core mbrx_checker u_mbrx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
